// ===== rtl/plsa_pkg.sv =====
package plsa_pkg;

   // field widths fixed by the item format
   localparam int CMD_W   = 2;
   localparam int POS_W   = 7;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   // operation codes
   typedef enum logic [CMD_W-1:0] {
      CMD_GET    = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef logic signed [DATA_W-1:0] data_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic do_insert;
      logic do_delete;
   } cell_ctrl_type;

endpackage

// ===== rtl/plsa_if.sv =====
interface plsa_req_if;
   logic                              valid;
   logic                              ready;
   logic [plsa_pkg::CMD_W-1:0]        cmd;
   logic [plsa_pkg::POS_W-1:0]        position;
   logic signed [plsa_pkg::DATA_W-1:0] value;

   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface plsa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              status;
   logic signed [plsa_pkg::DATA_W-1:0] read_value;
   logic [plsa_pkg::COUNT_W-1:0]      count;

   modport source (output valid, output status, output read_value, output count, input ready);
   modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

// ===== rtl/positional_list_shift_array.sv =====
// channel   port     direction  payload
// request   req_ch   in         cmd, position, value
// response  rsp_ch   out        status, read_value, count
//
// one item per cycle while the response is not stalled: every cell loads its neighbour in the same cycle,
// and the response is registered, so a result leaves in the cycle after its item is taken.
// the read path is a masked or over all cells, set by CAPACITY.
// reset clears the element count and the response valid and holds off requests.
// a stalled response holds the request side only while its register is full.
module positional_list_shift_array #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   plsa_req_if.sink   req_ch,
   plsa_rsp_if.source rsp_ch
);
   import plsa_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              status_ff, status_in;
   data_type          read_value_ff, read_value_in;

   logic              accept;
   cmd_type           cmd;
   logic [CMP_W-1:0]  pos_c, cnt_c;
   logic              in_list, ins_ok;
   logic [IDX_W-1:0]  pos_idx;
   cell_ctrl_type     ctrl;
   data_type          cell_data [CAPACITY];
   data_type          cell_rd   [CAPACITY];
   data_type          rd_or;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign cmd = cmd_type'(req_ch.cmd);

   // position checks against the current length
   assign pos_c   = CMP_W'(req_ch.position);
   assign cnt_c   = CMP_W'(count_ff);
   assign in_list = (pos_c != '0) && (pos_c <= cnt_c);
   assign ins_ok  = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1)) && (cnt_c < CAP_C);
   assign pos_idx = IDX_W'(pos_c - CMP_W'(1));

   // broadcast control for the row of cells
   always_comb begin
      ctrl.do_insert = 1'b0;
      ctrl.do_delete = 1'b0;
      if (accept) begin
         unique case (cmd)
            CMD_INSERT: ctrl.do_insert = ins_ok;
            CMD_DELETE: ctrl.do_delete = in_list;
            default:    ctrl = '0;
         endcase
      end
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_data[i+1];
      end
      plsa_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos_idx    (pos_idx),
         .ins_value  (req_ch.value),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // read-out: only the addressed cell drives non-zero
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   // next count and response
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      status_in     = status_ff;
      read_value_in = read_value_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         status_in     = 1'b1;
         read_value_in = '0;
         unique case (cmd)
            CMD_GET: begin
               if (in_list) begin
                  status_in     = 1'b0;
                  read_value_in = rd_or;
               end
            end
            CMD_INSERT: begin
               if (ins_ok) begin
                  status_in = 1'b0;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            CMD_DELETE: begin
               if (in_list) begin
                  status_in     = 1'b0;
                  read_value_in = rd_or;
                  count_in      = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.read_value = read_value_ff;
   assign rsp_ch.count      = COUNT_W'(count_ff);

endmodule

// ===== rtl/plsa_cell.sv =====
module plsa_cell #(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  plsa_pkg::cell_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]               pos_idx,
   input  logic signed [plsa_pkg::DATA_W-1:0] ins_value,
   input  logic signed [plsa_pkg::DATA_W-1:0] left_data,
   input  logic signed [plsa_pkg::DATA_W-1:0] right_data,
   output logic signed [plsa_pkg::DATA_W-1:0] data,
   output logic signed [plsa_pkg::DATA_W-1:0] rd_data
);
   import plsa_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   data_type data_ff;
   data_type data_in;
   logic     hit;
   logic     above;

   assign hit   = (pos_idx == MY_IDX);
   assign above = (MY_IDX > pos_idx);

   // insert: take the new item here, take the left neighbour above it
   // delete: take the right neighbour from the addressed place upwards
   always_comb begin
      data_in = data_ff;
      if (ctrl.do_insert) begin
         if (hit) begin
            data_in = ins_value;
         end else if (above) begin
            data_in = left_data;
         end
      end else if (ctrl.do_delete) begin
         if (hit || above) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   // masked contents feed the read-out or tree
   assign rd_data = hit ? data_ff : '0;

endmodule
